// File: rtl/psr_pkg.sv
// Shared types, constants and helper functions for the point scale/rotate unit.
// No dependencies; every other file in rtl/ imports this package.
package psr_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	localparam int FUNC_W  = 3;
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int DIFF_W  = COORD_W + 1;   // coordinate minus center
	localparam int CS_W    = 32;            // CORDIC x/y, Q28
	localparam int CZ_W    = 33;            // CORDIC angle, Q30
	localparam int PROD_W  = DIFF_W + CS_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int FRAC_SH = 28;
	localparam int RND_W   = ACC_W - FRAC_SH;
	localparam int SUM_W   = RND_W + 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_SCALE_UP   = 3'd0,
		FN_SCALE_DOWN = 3'd1,
		FN_ROT_X      = 3'd2,
		FN_ROT_Y      = 3'd3,
		FN_ROT_Z      = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 1'd0,
		REG_CENTER_Y = 1'd1
	} cfg_reg_t;

	// Q16 scale factors pre-shifted to Q28 so scaling shares the rotation rounding
	localparam logic signed [CS_W-1:0] SCALE_UP_Q28   = 32'sd295280640;  // 72090 << 12
	localparam logic signed [CS_W-1:0] SCALE_DOWN_Q28 = 32'sd244031488;  // 59578 << 12

	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic [63:0] GAIN_Q28      = 64'd163008219;
	localparam logic [63:0] GAIN_CORR_Q28 = 64'd108672146;
	localparam logic signed [ACC_W-1:0] ROUND_Q28 = ACC_W'(64'sd134217728);

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
	} pt_t;

	typedef struct packed {
		logic signed [CS_W-1:0] x;
		logic signed [CS_W-1:0] y;
		logic signed [CZ_W-1:0] z;
		logic                   flip;
	} rot_t;

	function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
		logic signed [CZ_W-1:0] v;
		unique case (i)
			0:  v = 33'sd843314857;
			1:  v = 33'sd497837829;
			2:  v = 33'sd263043837;
			3:  v = 33'sd133525159;
			4:  v = 33'sd67021687;
			5:  v = 33'sd33543516;
			6:  v = 33'sd16775851;
			7:  v = 33'sd8388437;
			8:  v = 33'sd4194283;
			9:  v = 33'sd2097149;
			default: v = (i < ATAN_LEN) ? (33'sd1 <<< (30 - i)) : 33'sd0;
		endcase
		return v;
	endfunction

	// gain start value, corrected for the finite stage count
	function automatic logic signed [CS_W-1:0] cordic_start(input int n);
		int          sh;
		logic [63:0] corr;
		sh   = 2 * n;
		corr = (GAIN_CORR_Q28 + (64'd1 << (sh - 1))) >> sh;
		return CS_W'(GAIN_Q28 + corr);
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SUM_W'(64'sd2147483647))
			r = 32'sh7fffffff;
		else if (v < SUM_W'(-64'sd2147483648))
			r = 32'sh80000000;
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/psr_front.sv
// Input stage: centre offsets, angle conversion to Q30 and quadrant fold.
// Depends on psr_pkg.
module psr_front #(
	parameter int CORDIC_STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_vld,
	input  logic [psr_pkg::FUNC_W-1:0]           func,
	input  logic signed [psr_pkg::COORD_W-1:0]   x_in,
	input  logic signed [psr_pkg::COORD_W-1:0]   y_in,
	input  logic signed [psr_pkg::COORD_W-1:0]   z_in,
	input  logic signed [psr_pkg::ANGLE_W-1:0]   angle,
	input  logic signed [psr_pkg::COORD_W-1:0]   center_x,
	input  logic signed [psr_pkg::COORD_W-1:0]   center_y,
	output logic                                 vld_s1,
	output psr_pkg::pt_t                         pt_s1,
	output psr_pkg::rot_t                        rot_s1
);
	import psr_pkg::*;

	localparam logic signed [CS_W-1:0] START = cordic_start(CORDIC_STAGES);

	logic signed [33:0]   ang_w;
	logic signed [33:0]   ang_f;
	logic                 flip;
	pt_t                  pt_d;
	rot_t                 rot_d;

	always_comb begin
		ang_w = 34'($signed({angle, 17'b0}));
		flip  = 1'b0;
		ang_f = ang_w;
		// beyond +-pi/2: move by pi toward zero, negate sin/cos afterwards
		if (ang_w > HALF_PI_Q30) begin
			ang_f = ang_w - PI_Q30;
			flip  = 1'b1;
		end else if (ang_w < -HALF_PI_Q30) begin
			ang_f = ang_w + PI_Q30;
			flip  = 1'b1;
		end
		pt_d.func = func;
		pt_d.x    = x_in;
		pt_d.y    = y_in;
		pt_d.z    = z_in;
		pt_d.dx   = DIFF_W'(x_in) - DIFF_W'(center_x);
		pt_d.dy   = DIFF_W'(y_in) - DIFF_W'(center_y);
		rot_d.x    = START;
		rot_d.y    = '0;
		rot_d.z    = ang_f[CZ_W-1:0];
		rot_d.flip = flip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1  <= pt_d;
			rot_s1 <= rot_d;
		end
	end

endmodule

// File: rtl/psr_cordic_stage.sv
// One registered micro-rotation of the CORDIC; carries the point alongside.
// Depends on psr_pkg.
module psr_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  psr_pkg::rot_t rot_in,
	input  psr_pkg::pt_t  pt_in,
	output logic          vld_s1,
	output psr_pkg::rot_t rot_s1,
	output psr_pkg::pt_t  pt_s1
);
	import psr_pkg::*;

	localparam logic signed [CZ_W-1:0] ATAN = atan_q30(IDX);

	logic signed [CS_W-1:0] xs;
	logic signed [CS_W-1:0] ys;
	rot_t                   rot_d;

	always_comb begin
		xs = rot_in.x >>> IDX;
		ys = rot_in.y >>> IDX;
		rot_d.flip = rot_in.flip;
		if (!rot_in.z[CZ_W-1]) begin
			rot_d.x = rot_in.x - ys;
			rot_d.y = rot_in.y + xs;
			rot_d.z = rot_in.z - ATAN;
		end else begin
			rot_d.x = rot_in.x + ys;
			rot_d.y = rot_in.y - xs;
			rot_d.z = rot_in.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= rot_d;
			pt_s1  <= pt_in;
		end
	end

endmodule

// File: rtl/psr_cordic.sv
// CORDIC pipeline: CORDIC_STAGES micro-rotation stages producing cos/sin in Q28.
// Depends on psr_pkg and psr_cordic_stage.
module psr_cordic #(
	parameter int CORDIC_STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  psr_pkg::rot_t rot_in,
	input  psr_pkg::pt_t  pt_in,
	output logic          vld_out,
	output psr_pkg::rot_t rot_out,
	output psr_pkg::pt_t  pt_out
);
	import psr_pkg::*;

	logic [CORDIC_STAGES:0] vld_a;
	rot_t                   rot_a [CORDIC_STAGES+1];
	pt_t                    pt_a  [CORDIC_STAGES+1];

	assign vld_a[0] = vld_in;
	assign rot_a[0] = rot_in;
	assign pt_a[0]  = pt_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		psr_cordic_stage #(
			.IDX (i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld_a[i]),
			.rot_in (rot_a[i]),
			.pt_in  (pt_a[i]),
			.vld_s1 (vld_a[i+1]),
			.rot_s1 (rot_a[i+1]),
			.pt_s1  (pt_a[i+1])
		);
	end

	assign vld_out = vld_a[CORDIC_STAGES];
	assign rot_out = rot_a[CORDIC_STAGES];
	assign pt_out  = pt_a[CORDIC_STAGES];

	localparam logic signed [CZ_W-1:0] Z_TOL = atan_q30(CORDIC_STAGES - 1) <<< 1;

	// residual angle must have converged
	a_z_conv: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out |-> (rot_out.z <= Z_TOL) && (rot_out.z >= -Z_TOL))
		else $error("cordic residual angle out of range");

	// x and y of the vector stay below 2.0 in magnitude in Q28
	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out |-> (rot_out.x < 32'sd536870912) && (rot_out.x > -32'sd536870912)
		         && (rot_out.y < 32'sd536870912) && (rot_out.y > -32'sd536870912))
		else $error("cordic output magnitude out of range");

endmodule

// File: rtl/psr_back.sv
// Back end: operand select and products, exact sums with rounding bias,
// then Q28 rounding, center add, saturation and the output register. Depends on psr_pkg.
module psr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  psr_pkg::rot_t                       rot_in,
	input  psr_pkg::pt_t                        pt_in,
	input  logic signed [psr_pkg::COORD_W-1:0]  center_x,
	input  logic signed [psr_pkg::COORD_W-1:0]  center_y,
	output logic                                res_vld_q,
	output logic signed [psr_pkg::COORD_W-1:0]  x_out,
	output logic signed [psr_pkg::COORD_W-1:0]  y_out,
	output logic signed [psr_pkg::COORD_W-1:0]  z_out
);
	import psr_pkg::*;

	logic                   is_scale;
	logic                   neg_s;
	logic signed [CS_W-1:0]   c_sel;
	logic signed [CS_W-1:0]   s_sel;
	logic signed [DIFF_W-1:0] u_sel;
	logic signed [DIFF_W-1:0] v_sel;

	logic                     vld_s1;
	pt_t                      pt_s1;
	logic signed [PROD_W-1:0] uc_s1, vs_s1, vc_s1, us_s1, wc_s1;

	logic                    vld_s2;
	pt_t                     pt_s2;
	logic signed [ACC_W-1:0] p_s2, q_s2, w_s2;

	logic signed [SUM_W-1:0]   p_r, q_r, w_r;
	logic signed [COORD_W-1:0] rx, ry, rz;

	// p = u*c + v*s, q = v*c - u*s; rotation about z uses -s, scaling uses s = 0
	always_comb begin
		is_scale = (pt_in.func == FN_SCALE_UP) || (pt_in.func == FN_SCALE_DOWN);
		neg_s    = rot_in.flip ^ (pt_in.func == FN_ROT_Z);
		if (is_scale) begin
			c_sel = (pt_in.func == FN_SCALE_UP) ? SCALE_UP_Q28 : SCALE_DOWN_Q28;
			s_sel = '0;
		end else begin
			c_sel = rot_in.flip ? -rot_in.x : rot_in.x;
			s_sel = neg_s ? -rot_in.y : rot_in.y;
		end
		u_sel = (pt_in.func == FN_ROT_X) ? pt_in.dy : pt_in.dx;
		v_sel = ((pt_in.func == FN_ROT_X) || (pt_in.func == FN_ROT_Y)) ?
			DIFF_W'(pt_in.z) : pt_in.dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= vld_in;
			vld_s2    <= vld_s1;
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= pt_in;
			uc_s1 <= PROD_W'(u_sel) * PROD_W'(c_sel);
			vs_s1 <= PROD_W'(v_sel) * PROD_W'(s_sel);
			vc_s1 <= PROD_W'(v_sel) * PROD_W'(c_sel);
			us_s1 <= PROD_W'(u_sel) * PROD_W'(s_sel);
			wc_s1 <= PROD_W'(pt_in.z) * PROD_W'(c_sel);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2 <= pt_s1;
			p_s2  <= ACC_W'(uc_s1) + ACC_W'(vs_s1) + ROUND_Q28;
			q_s2  <= ACC_W'(vc_s1) - ACC_W'(us_s1) + ROUND_Q28;
			w_s2  <= ACC_W'(wc_s1) + ROUND_Q28;
		end
	end

	always_comb begin
		p_r = SUM_W'($signed(p_s2[ACC_W-1:FRAC_SH]));
		q_r = SUM_W'($signed(q_s2[ACC_W-1:FRAC_SH]));
		w_r = SUM_W'($signed(w_s2[ACC_W-1:FRAC_SH]));
		rx  = pt_s2.x;
		ry  = pt_s2.y;
		rz  = pt_s2.z;
		unique case (pt_s2.func)
			FN_SCALE_UP, FN_SCALE_DOWN: begin
				rx = sat32(p_r + SUM_W'(center_x));
				ry = sat32(q_r + SUM_W'(center_y));
				rz = sat32(w_r);
			end
			FN_ROT_X: begin
				ry = sat32(p_r + SUM_W'(center_y));
				rz = sat32(q_r);
			end
			FN_ROT_Y: begin
				rx = sat32(p_r + SUM_W'(center_x));
				rz = sat32(q_r);
			end
			FN_ROT_Z: begin
				rx = sat32(p_r + SUM_W'(center_x));
				ry = sat32(q_r + SUM_W'(center_y));
			end
			default: begin
				// unused codes pass the point through
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= rx;
			y_out <= ry;
			z_out <= rz;
		end
	end

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(vld_s2))
		else $error("result valid without an item in the sum stage");

endmodule

// File: rtl/point_scale_rotate_unit.sv
// Point scale/rotate unit: one point per cycle sustained while not stalled; the
// input stage, CORDIC_STAGES micro-rotations, a product stage, a sum stage and
// the output register all advance together.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
// Reset clears all valid bits and both centre registers to zero.
module point_scale_rotate_unit #(
	parameter int CORDIC_STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [111:0]               s_axis_tdata,  // x_in, y_in, z_in, angle
	input  logic [psr_pkg::FUNC_W-1:0] s_axis_tuser,  // func
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [95:0]                m_axis_tdata,  // x_out, y_out, z_out
	input  logic                          cfg_wr_en,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::CFG_W-1:0]     cfg_wdata
);
	import psr_pkg::*;

	logic                      en;
	logic signed [COORD_W-1:0] center_x_q;
	logic signed [COORD_W-1:0] center_y_q;

	logic f_vld;
	pt_t  f_pt;
	rot_t f_rot;
	logic c_vld;
	pt_t  c_pt;
	rot_t c_rot;
	logic signed [COORD_W-1:0] x_out, y_out, z_out;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tdata  = {z_out, y_out, x_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
			endcase
		end
	end

	psr_front #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_axis_tvalid),
		.func     (s_axis_tuser),
		.x_in     ($signed(s_axis_tdata[31:0])),
		.y_in     ($signed(s_axis_tdata[63:32])),
		.z_in     ($signed(s_axis_tdata[95:64])),
		.angle    ($signed(s_axis_tdata[111:96])),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.vld_s1   (f_vld),
		.pt_s1    (f_pt),
		.rot_s1   (f_rot)
	);

	psr_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (f_vld),
		.rot_in  (f_rot),
		.pt_in   (f_pt),
		.vld_out (c_vld),
		.rot_out (c_rot),
		.pt_out  (c_pt)
	);

	psr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (c_vld),
		.rot_in    (c_rot),
		.pt_in     (c_pt),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.res_vld_q (m_axis_tvalid),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out)
	);

endmodule

// File: tb/tb_point_scale_rotate_unit.sv
// Self-checking bench for point_scale_rotate_unit: scale and CORDIC rotation of Q16.16 points.
// Needs psr_pkg and the unit; a scoreboard class predicts each output word from the input word.
`timescale 1ns / 1ps

module tb_point_scale_rotate_unit;
	import psr_pkg::*;

	localparam int          STAGES       = CORDIC_STAGES_DEF;
	localparam int          LATENCY      = STAGES + 4;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          MAX_REPORTS  = 10;
	localparam longint      K_UP_Q16     = 72090;
	localparam longint      K_DOWN_Q16   = 59578;
	localparam longint      ANG_PI       = 64'sd3373259426;
	localparam longint      ANG_HALF_PI  = 64'sd1686629713;
	localparam longint      CORDIC_GAIN  = 64'sd163008219;
	localparam logic [63:0] GAIN_FIX     = 64'd108672146;
	localparam logic [2:0]  FN_UNUSED_LO = 3'd5;
	localparam logic [2:0]  FN_UNUSED_HI = 3'd7;
	localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN        = 32'h8000_0000;
	localparam logic [15:0] ANG_PI_Q13   = 16'd25736;
	localparam logic [15:0] ANG_EDGE_Q13 = 16'd12868;   // first angle past pi/2

	// atan(2^-i) in Q30
	localparam longint ATAN_TAB [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	typedef struct packed {
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} point_word_t;

	class point_board;
		point_word_t expected_q[$];
		longint      cx;
		longint      cy;
		int          errors;

		function new();
			cx = 0;
			cy = 0;
			errors = 0;
		endfunction

		function void set_center(cfg_reg_t idx, logic [31:0] v);
			if (idx == REG_CENTER_X)
				cx = longint'(signed'(v));
			else
				cy = longint'(signed'(v));
		endfunction

		function logic [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return Q_MAX;
			if (v < -64'sd2147483648)
				return Q_MIN;
			return v[31:0];
		endfunction

		// cosine and sine in Q28 for a Q2.13 angle
		function void sincos_cordic(input longint ang, output longint cq, output longint sq);
			longint zq;
			longint xq;
			longint yq;
			longint xs;
			longint ys;
			bit     flip;
			int     sh;
			zq = ang * 131072;
			flip = 1'b0;
			if (zq > ANG_HALF_PI) begin
				zq -= ANG_PI;
				flip = 1'b1;
			end else if (zq < -ANG_HALF_PI) begin
				zq += ANG_PI;
				flip = 1'b1;
			end
			sh = 2 * STAGES;
			xq = CORDIC_GAIN;
			if (sh < 63)
				xq += longint'((GAIN_FIX + ((64'd1 << sh) >> 1)) >> sh);
			yq = 0;
			for (int i = 0; i < STAGES && i < 24; i++) begin
				xs = xq >>> i;
				ys = yq >>> i;
				if (zq >= 0) begin
					xq -= ys;
					yq += xs;
					zq -= ATAN_TAB[i];
				end else begin
					xq += ys;
					yq -= xs;
					zq += ATAN_TAB[i];
				end
			end
			cq = flip ? -xq : xq;
			sq = flip ? -yq : yq;
		endfunction

		function point_word_t transform_point(logic [2:0] fn, logic [31:0] xi, logic [31:0] yi,
				logic [31:0] zi, logic [15:0] ang);
			point_word_t r;
			longint      x;
			longint      y;
			longint      z;
			longint      dx;
			longint      dy;
			longint      k;
			longint      c;
			longint      s;
			longint      rx;
			longint      ry;
			longint      rz;
			x = longint'(signed'(xi));
			y = longint'(signed'(yi));
			z = longint'(signed'(zi));
			dx = x - cx;
			dy = y - cy;
			rx = x;
			ry = y;
			rz = z;
			case (fn)
				FN_SCALE_UP, FN_SCALE_DOWN: begin
					k = (fn == FN_SCALE_UP) ? K_UP_Q16 : K_DOWN_Q16;
					rx = ((dx * k + 32768) >>> 16) + cx;
					ry = ((dy * k + 32768) >>> 16) + cy;
					rz = (z * k + 32768) >>> 16;
				end
				FN_ROT_X: begin
					sincos_cordic(longint'(signed'(ang)), c, s);
					ry = ((dy * c + z * s + 134217728) >>> 28) + cy;
					rz = (z * c - dy * s + 134217728) >>> 28;
				end
				FN_ROT_Y: begin
					sincos_cordic(longint'(signed'(ang)), c, s);
					rx = ((dx * c + z * s + 134217728) >>> 28) + cx;
					rz = (z * c - dx * s + 134217728) >>> 28;
				end
				FN_ROT_Z: begin
					sincos_cordic(longint'(signed'(ang)), c, s);
					rx = ((dx * c - dy * s + 134217728) >>> 28) + cx;
					ry = ((dx * s + dy * c + 134217728) >>> 28) + cy;
				end
				default: ;   // unused codes pass the point through
			endcase
			r.x = clamp32(rx);
			r.y = clamp32(ry);
			r.z = clamp32(rz);
			return r;
		endfunction

		function void note_input(logic [2:0] fn, logic [31:0] xi, logic [31:0] yi,
				logic [31:0] zi, logic [15:0] ang);
			expected_q.push_back(transform_point(fn, xi, yi, zi, ang));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void check_field(string name, logic [31:0] e, logic [31:0] g);
			if (g !== e) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch on %s: expected %h, got %h", name, e, g);
			end
		endfunction

		function void check_result(point_word_t got);
			point_word_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("output word %h with nothing expected", got);
				return;
			end
			e = expected_q.pop_front();
			check_field("x_out", e.x, got.x);
			check_field("y_out", e.y, got.y);
			check_field("z_out", e.z, got.z);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [111:0]         s_axis_tdata = '0;   // x_in, y_in, z_in, angle
	logic [FUNC_W-1:0]    s_axis_tuser = '0;   // func
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [95:0]          m_axis_tdata;        // x_out, y_out, z_out
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	point_board board = new();
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	int         cycle_count = 0;

	point_scale_rotate_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// output side: check accepted words, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(point_word_t'(m_axis_tdata));
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// mix of magnitudes, full range down to a few LSBs
	function automatic logic [31:0] rand_coord();
		int v;
		v = $urandom;
		return v >>> $urandom_range(0, 26);
	endfunction

	task automatic send_point(input logic [2:0] fn, input logic [31:0] xi, input logic [31:0] yi,
			input logic [31:0] zi, input logic [15:0] ang);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {ang, zi, yi, xi};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_input(fn, xi, yi, zi, ang);
	endtask

	task automatic set_centers(input logic [31:0] cx, input logic [31:0] cy);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_wdata <= cx;
		@(posedge clk);
		board.set_center(REG_CENTER_X, cx);
		cfg_index <= REG_CENTER_Y;
		cfg_wdata <= cy;
		@(posedge clk);
		board.set_center(REG_CENTER_Y, cy);
		cfg_wr_en <= 1'b0;
	endtask

	// random words, then drain so the centres can change
	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
		logic [2:0]  fn;
		logic [15:0] ang;
		int          a;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (n_items) begin
			if ($urandom_range(0, 19) == 0)
				fn = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
			else
				fn = 3'($urandom_range(FN_SCALE_UP, FN_ROT_Z));
			if ($urandom_range(0, 4) == 0) begin
				ang = 16'($urandom);
			end else begin
				a = int'($urandom_range(0, 2 * ANG_PI_Q13)) - int'(ANG_PI_Q13);
				ang = a[15:0];
			end
			send_point(fn, rand_coord(), rand_coord(), rand_coord(), ang);
		end
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_centers('0, '0);

		send_point(FN_SCALE_UP, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, '0);
		send_point(FN_SCALE_DOWN, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, '0);
		send_point(FN_SCALE_UP, Q_MAX, Q_MIN, Q_MAX, '0);
		send_point(FN_SCALE_DOWN, Q_MIN, Q_MAX, Q_MIN, 16'hffff);
		send_point(FN_SCALE_DOWN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, '0);
		send_point(FN_SCALE_UP, '0, '0, '0, '0);
		send_point(FN_ROT_X, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, '0);
		send_point(FN_ROT_Y, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, ANG_EDGE_Q13 - 1);
		send_point(FN_ROT_Z, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, ANG_EDGE_Q13);
		send_point(FN_ROT_Z, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, -ANG_EDGE_Q13);
		send_point(FN_ROT_X, 32'h0007_8000, 32'hfff2_4000, 32'h0010_0000, ANG_PI_Q13);
		send_point(FN_ROT_Y, 32'h0007_8000, 32'hfff2_4000, 32'h0010_0000, -ANG_PI_Q13);
		// beyond +-pi, down to the most negative angle word
		send_point(FN_ROT_Z, 32'h0007_8000, 32'hfff2_4000, 32'h0010_0000, 16'h7fff);
		send_point(FN_ROT_X, 32'h0007_8000, 32'hfff2_4000, 32'h0010_0000, 16'h8000);
		send_point(FN_ROT_Z, Q_MAX, Q_MAX, Q_MAX, ANG_EDGE_Q13 >> 1);
		send_point(FN_ROT_Y, Q_MIN, Q_MAX, Q_MAX, -(ANG_EDGE_Q13 >> 1));
		send_point(FN_ROT_X, Q_MAX, Q_MIN, Q_MIN, ANG_EDGE_Q13 >> 1);
		send_point(FN_ROT_X, '0, 32'hffff_ffff, 32'h0000_0001, 16'h0001);
		send_point(FN_ROT_Z, '0, '0, '0, 16'hffff);
		send_point(FN_UNUSED_LO, Q_MAX, Q_MIN, 32'h1234_5678, 16'h5555);
		send_point(FN_UNUSED_LO + 3'd1, Q_MIN, Q_MAX, 32'hedcb_a987, 16'haaaa);
		send_point(FN_UNUSED_HI, 32'hffff_ffff, '0, Q_MAX, 16'hffff);

		run_phase(0, 0, 160);
		set_centers(rand_coord(), rand_coord());
		run_phase(75, 0, 160);
		set_centers(Q_MAX, Q_MIN);
		run_phase(0, 75, 150);
		set_centers(Q_MIN, Q_MAX);
		run_phase(31, 31, 160);
		set_centers(32'hfffe_8000, 32'h0002_4000);
		run_phase(0, 0, 160);
		set_centers(rand_coord(), rand_coord());
		run_phase(31, 31, 160);

		repeat (LATENCY + 8) @(posedge clk);
		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
